>>> rtl/jrcpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrcpm_pkg : joystick to RC pulse mapper package
// Payload types, event codes, pulse limits and axis scaling constants.
// ----------------------------------------------------------------------------
package jrcpm_pkg;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         button_index;
    logic               pressed;
    logic [2:0]         axis_index;
    logic signed [15:0] axis_value;
  } jrcpm_in_t;

  typedef struct packed {
    logic        kind;
    logic        override_on;
    logic [10:0] armed_pulse;
    logic [10:0] roll_pulse;
    logic [10:0] pitch_pulse;
    logic [10:0] throttle_pulse;
  } jrcpm_out_t;

  // event kinds
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_AXIS   = 1'b1;

  // buttons
  localparam logic [4:0] BTN_OVERRIDE = 5'd0;
  localparam logic [4:0] BTN_ARM      = 5'd1;
  localparam logic [4:0] BTN_THR_UP   = 5'd11;
  localparam logic [4:0] BTN_THR_DOWN = 5'd12;

  // axes
  localparam logic [2:0] AXIS_ROLL     = 3'd2;
  localparam logic [2:0] AXIS_PITCH    = 3'd3;
  localparam logic [2:0] AXIS_THROTTLE = 3'd5;

  // result kinds
  localparam logic KIND_MODE = 1'b0;
  localparam logic KIND_CHAN = 1'b1;

  // pulse widths in microseconds
  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MID = 11'd1500;
  localparam logic [10:0] PULSE_MAX = 11'd2000;

  localparam logic [6:0] THROTTLE_STEP_RST = 7'd10;

  // Q15 axis scaling
  localparam logic [14:0]        Q15_ONE     = 15'd32767;
  localparam logic signed [15:0] Q15_MOST_NEG = 16'sh8000;
  localparam logic signed [15:0] Q15_NEG_ONE  = -16'sd32767;

  localparam int unsigned DEAD_ZONE = 3277;
  localparam logic [14:0] DEAD_ZONE_Q15 = 15'(DEAD_ZONE);
  localparam int unsigned SPAN = 32767 - DEAD_ZONE;

  // 500*x/SPAN as (x*CM_K) >> CM_SHIFT, rounded-up reciprocal; exact for x <= SPAN
  localparam int unsigned CM_SHIFT = 31;
  localparam int unsigned CM_KW    = 27;
  localparam longint unsigned CM_K_FULL =
    ((64'd500 << CM_SHIFT) + 64'(SPAN) - 64'd1) / 64'(SPAN);
  localparam logic [CM_KW-1:0] CM_K = CM_KW'(CM_K_FULL);

endpackage

>>> rtl/joystick_to_rc_pulse_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_to_rc_pulse_mapper : joystick events to four RC pulse widths
// Buttons toggle override and arm and step the throttle; axes set roll,
// pitch and throttle. Channel results go out only in override mode.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                          Carries
//  -------  -------------------------------  -------------------------------
//  evt      evt_valid, evt_ready, evt        one joystick event (jrcpm_in_t)
//  pulse    pulse_valid, pulse_ready, pulse  mode change or channel update
//  cfg      cfg_valid, cfg_ready,            throttle step per button press
//           cfg_throttle_step
//
//  Cycles : one event per cycle sustained while results are taken. An event
//           waits in the input register, and its result is registered in
//           the result register. The path is set by the axis scaling
//           multiplier in jrcpm_axis_map.
//  Reset  : synchronous; override off, all levels 1000, step 10, both
//           registers empty. No clearing pass.
//  Stalls : a held result blocks the input register only; events with no
//           result still need the result slot free before they retire.
//
module joystick_to_rc_pulse_mapper
  import jrcpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_ready,
  input  jrcpm_in_t  evt,
  output logic       pulse_valid,
  input  logic       pulse_ready,
  output jrcpm_out_t pulse,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_throttle_step
);

  // input register
  jrcpm_in_t   in_q;
  logic        in_full;
  logic        adv;

  // block state
  logic        override_mode, override_mode_next;
  logic [10:0] armed_level, armed_level_next;
  logic [10:0] roll_level, roll_level_next;
  logic [10:0] pitch_level, pitch_level_next;
  logic [10:0] throttle_level, throttle_level_next;
  logic [6:0]  throttle_step;

  logic        emit;
  logic        emit_kind;
  logic [10:0] axis_level;
  logic [11:0] thr_up_sum;
  logic [11:0] thr_down_floor;

  // retire the held event once the result slot is free or being drained
  assign adv       = in_full && (!pulse_valid || pulse_ready);
  assign evt_ready = !in_full || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (evt_valid && evt_ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  // payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      in_q <= evt;
    end
  end

  jrcpm_axis_map u_axis_map (
    .axis_index (in_q.axis_index),
    .axis_value (in_q.axis_value),
    .level      (axis_level)
  );

  assign thr_up_sum     = {1'b0, throttle_level} + {5'd0, throttle_step};
  assign thr_down_floor = {1'b0, PULSE_MIN} + {5'd0, throttle_step};

  // next state and result decision for the event in the input register
  always_comb begin
    override_mode_next  = override_mode;
    armed_level_next    = armed_level;
    roll_level_next     = roll_level;
    pitch_level_next    = pitch_level;
    throttle_level_next = throttle_level;
    emit                = 1'b0;
    emit_kind           = KIND_CHAN;

    if (in_q.opcode == OP_BUTTON) begin
      // release events do nothing
      if (in_q.pressed) begin
        unique case (in_q.button_index)
          BTN_OVERRIDE: begin
            override_mode_next = !override_mode;
            emit               = 1'b1;
            emit_kind          = KIND_MODE;
          end
          BTN_ARM: begin
            if (override_mode) begin
              armed_level_next = (armed_level > PULSE_MID) ? PULSE_MIN : PULSE_MAX;
              emit             = 1'b1;
            end
          end
          BTN_THR_UP: begin
            // step only while the result stays within the top limit
            if (override_mode && (thr_up_sum <= {1'b0, PULSE_MAX})) begin
              throttle_level_next = thr_up_sum[10:0];
              emit                = 1'b1;
            end
          end
          BTN_THR_DOWN: begin
            if (override_mode && ({1'b0, throttle_level} >= thr_down_floor)) begin
              throttle_level_next = throttle_level - {4'd0, throttle_step};
              emit                = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      // axes update their level even outside override; report only a change
      unique case (in_q.axis_index)
        AXIS_THROTTLE: begin
          throttle_level_next = axis_level;
          emit = override_mode && (axis_level != throttle_level);
        end
        AXIS_ROLL: begin
          roll_level_next = axis_level;
          emit = override_mode && (axis_level != roll_level);
        end
        AXIS_PITCH: begin
          pitch_level_next = axis_level;
          emit = override_mode && (axis_level != pitch_level);
        end
        default: begin
        end
      endcase
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      override_mode  <= 1'b0;
      armed_level    <= PULSE_MIN;
      roll_level     <= PULSE_MIN;
      pitch_level    <= PULSE_MIN;
      throttle_level <= PULSE_MIN;
      throttle_step  <= THROTTLE_STEP_RST;
    end else begin
      if (adv) begin
        override_mode  <= override_mode_next;
        armed_level    <= armed_level_next;
        roll_level     <= roll_level_next;
        pitch_level    <= pitch_level_next;
        throttle_level <= throttle_level_next;
      end
      if (cfg_valid && cfg_ready) begin
        throttle_step <= cfg_throttle_step;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (adv && emit) begin
      pulse_valid <= 1'b1;
    end else if (pulse_ready) begin
      pulse_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      pulse.kind           <= emit_kind;
      pulse.override_on    <= override_mode_next;
      pulse.armed_pulse    <= armed_level_next;
      pulse.roll_pulse     <= roll_level_next;
      pulse.pitch_pulse    <= pitch_level_next;
      pulse.throttle_pulse <= throttle_level_next;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_arm_two_levels: assert property (@(posedge clk) disable iff (rst)
    (armed_level == PULSE_MIN) || (armed_level == PULSE_MAX))
    else $error("arm level left its two settings");

  a_levels_in_range: assert property (@(posedge clk) disable iff (rst)
    (roll_level >= PULSE_MIN) && (roll_level <= PULSE_MAX) &&
    (pitch_level >= PULSE_MIN) && (pitch_level <= PULSE_MAX) &&
    (throttle_level >= PULSE_MIN) && (throttle_level <= PULSE_MAX))
    else $error("channel level outside 1000..2000");

  a_chan_only_in_override: assert property (@(posedge clk) disable iff (rst)
    pulse_valid && (pulse.kind == KIND_CHAN) |-> pulse.override_on)
    else $error("channel result outside override");

  a_mode_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    adv && emit && (emit_kind == KIND_MODE) |=>
      pulse_valid && (pulse.override_on == override_mode) &&
      (override_mode != $past(override_mode)))
    else $error("mode result does not match toggled override state");

  a_held_event_stable: assert property (@(posedge clk) disable iff (rst)
    in_full && !adv |=> in_full && $stable(in_q))
    else $error("held event lost or changed");

endmodule

>>> rtl/jrcpm_axis_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrcpm_axis_map : axis position to pulse width
// Throttle maps 0..+1 onto 1000..2000; roll and pitch map with a centre dead
// zone onto 1000..2000. Pitch is inverted.
// ----------------------------------------------------------------------------
module jrcpm_axis_map
  import jrcpm_pkg::*;
(
  input  logic [2:0]         axis_index,
  input  logic signed [15:0] axis_value,
  output logic [10:0]        level
);

  logic signed [15:0] v_c;
  logic signed [15:0] v_neg;
  logic [14:0]        mag;
  logic [14:0]        t;
  logic [24:0]        t_prod;
  logic [9:0]         t_hi;
  logic [15:0]        t_sum;
  logic [10:0]        t_quo;
  logic [10:0]        level_t;
  logic               u_neg;
  logic               dead;
  logic [14:0]        x;
  logic [14+CM_KW:0]  c_prod;
  logic [8:0]         c_quo;
  logic [10:0]        level_c;

  always_comb begin
    // clamp the most negative code to -1
    v_c   = (axis_value == Q15_MOST_NEG) ? Q15_NEG_ONE : axis_value;
    v_neg = -v_c;
    mag   = v_c[15] ? v_neg[14:0] : v_c[14:0];

    // throttle: 1000*t/32767 via n = a*2^15 + b = a*32767 + (a + b)
    t       = v_c[15] ? 15'd0 : v_c[14:0];
    t_prod  = {10'd0, t} * 25'd1000;
    t_hi    = t_prod[24:15];
    t_sum   = {6'd0, t_hi} + {1'b0, t_prod[14:0]};
    t_quo   = {1'b0, t_hi} + {10'd0, (t_sum >= {1'b0, Q15_ONE})};
    level_t = PULSE_MIN + t_quo;

    // roll / pitch with centre dead zone
    u_neg   = (axis_index == AXIS_PITCH) ? (!v_c[15] && (v_c != 16'sd0)) : v_c[15];
    dead    = (mag < DEAD_ZONE_Q15);
    x       = u_neg ? (Q15_ONE - mag) : (mag - DEAD_ZONE_Q15);
    c_prod  = {{CM_KW{1'b0}}, x} * {15'd0, CM_K};
    c_quo   = c_prod[CM_SHIFT+8:CM_SHIFT];
    level_c = dead ? PULSE_MID : ((u_neg ? PULSE_MIN : PULSE_MID) + {2'd0, c_quo});

    level = (axis_index == AXIS_THROTTLE) ? level_t : level_c;
  end

endmodule
